FILE: hdl/idl_pkg.sv
// Package for the indexed deque list: sizes, codes, controller/datapath interface types.
package idl_pkg;

  localparam int Capacity = 256;
  localparam int SlotW    = $clog2(Capacity);
  localparam int CntW     = $clog2(Capacity + 1);
  localparam int OpW      = 4;
  localparam int PosW     = 8;
  localparam int ValW     = 32;
  localparam int StatW    = 2;
  localparam int OutCntW  = 9;
  // wide enough to compare a position against the count without loss
  localparam int CmpW     = ((CntW > PosW) ? CntW : PosW) + 1;

  typedef enum logic [OpW-1:0] {
    OP_PUSH_BACK  = 4'd0,
    OP_PUSH_FRONT = 4'd1,
    OP_POP_BACK   = 4'd2,
    OP_POP_FRONT  = 4'd3,
    OP_INSERT     = 4'd4,
    OP_READ       = 4'd5,
    OP_WRITE      = 4'd6,
    OP_REMOVE     = 4'd7,
    OP_CLEAR      = 4'd8
  } op_e;

  typedef enum logic [StatW-1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_EMPTY = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SHIFT,
    S_RDWAIT,
    S_DONE
  } fsm_state_e;

  typedef struct packed {
    logic load_req;
    logic decode;
    logic shift;
    logic capture_rd;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic shift_needed;
    logic read_needed;
    logic shift_done;
  } dp_stat_t;

  // circular slot addition, both operands below Capacity
  function automatic logic [SlotW-1:0] slot_add(logic [SlotW-1:0] a, logic [SlotW-1:0] b);
    logic [SlotW:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= (SlotW+1)'(Capacity)) begin
      sum = sum - (SlotW+1)'(Capacity);
    end
    return sum[SlotW-1:0];
  endfunction

endpackage

FILE: hdl/indexed_deque_list.sv
// Top level of the indexed deque list: stream ports, controller and datapath.
//
//  channel  dir  handshake                   payload
//  s_axis   in   s_axis_tvalid_i/tready_o    tuser: op; tdata: position, value
//  m_axis   out  m_axis_tvalid_o/tready_i    tdata: read_value, status, count
//
// Request path: push, pop, write, clear, unused codes, refusals and end inserts/removes go
// IDLE, DECODE, DONE; an in-range read also passes RDWAIT; an insert or remove that moves
// n entries also passes SHIFT (n up to Capacity - 2, one entry per cycle).
// Reset clears head, count, the shift counter and pending flag (and the controller); the store holds no reset state.
// One finished result may wait on m_axis while the next request runs; a second finished
// result waits in the controller and keeps s_axis_tready_o low until the first is taken.
module indexed_deque_list import idl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,   // [7:0] position, [39:8] value
  input  logic [3:0]  s_axis_tuser_i,   // [3:0] op
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o    // [31:0] read_value, [33:32] status, [42:34] count
);

  dp_cmd_t            cmd;
  dp_stat_t           stat;
  logic [ValW-1:0]    out_value;
  logic [StatW-1:0]   out_status;
  logic [OutCntW-1:0] out_count;

  idl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .cmd_o      (cmd),
    .stat_i     (stat)
  );

  idl_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .req_op_i     (s_axis_tuser_i),
    .req_pos_i    (s_axis_tdata_i[7:0]),
    .req_value_i  (s_axis_tdata_i[39:8]),
    .out_value_o  (out_value),
    .out_status_o (out_status),
    .out_count_o  (out_count)
  );

  assign m_axis_tdata_o = {5'b0, out_count, out_status, out_value};

endmodule

FILE: hdl/idl_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered read data.
module idl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: hdl/idl_datapath.sv
// Datapath: request registers, head/count state, entry store, shift engine, result registers.
module idl_datapath import idl_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dp_cmd_t             cmd_i,
  output dp_stat_t            stat_o,
  input  logic [OpW-1:0]      req_op_i,
  input  logic [PosW-1:0]     req_pos_i,
  input  logic [ValW-1:0]     req_value_i,
  output logic [ValW-1:0]     out_value_o,
  output logic [StatW-1:0]    out_status_o,
  output logic [OutCntW-1:0]  out_count_o
);

  logic [OpW-1:0]     op_q;
  logic [PosW-1:0]    pos_q;
  logic [ValW-1:0]    val_q;
  logic [SlotW-1:0]   head_q, head_d;
  logic [CntW-1:0]    count_q, count_d;
  logic [SlotW-1:0]   rd_pos_q, rd_pos_d;
  logic [SlotW-1:0]   wpos_q, wpos_d;
  logic [CntW-1:0]    n_q, n_d;
  logic               pend_q, pend_d;
  logic               ins_q, ins_d;
  logic [StatW-1:0]   status_q, status_d;
  logic [ValW-1:0]    rdv_q, rdv_d;

  logic               ram_we;
  logic [SlotW-1:0]   ram_waddr;
  logic [ValW-1:0]    ram_wdata;
  logic [SlotW-1:0]   ram_raddr;
  logic [ValW-1:0]    ram_rdata;

  logic               pos_ok, full, empty, pos_zero, pos_last;
  logic [SlotW-1:0]   pos_slot, head_inc, head_dec;

  assign pos_ok   = CmpW'(pos_q) < CmpW'(count_q);
  assign full     = count_q >= CntW'(Capacity);
  assign empty    = count_q == '0;
  assign pos_zero = pos_q == '0;
  assign pos_last = (CmpW'(pos_q) + CmpW'(1)) == CmpW'(count_q);
  assign pos_slot = slot_add(head_q, SlotW'(pos_q));
  assign head_inc = slot_add(head_q, SlotW'(1));
  assign head_dec = (head_q == '0) ? SlotW'(Capacity - 1) : head_q - SlotW'(1);

  assign stat_o.shift_needed = ((op_q == OP_INSERT) && pos_ok && !full && !pos_zero) ||
                               ((op_q == OP_REMOVE) && pos_ok && !pos_zero && !pos_last);
  assign stat_o.read_needed  = (op_q == OP_READ) && pos_ok;
  assign stat_o.shift_done   = (n_q == '0) && !pend_q;

  assign ram_raddr = cmd_i.shift ? slot_add(head_q, rd_pos_q) : pos_slot;

  always_comb begin
    head_d    = head_q;
    count_d   = count_q;
    status_d  = status_q;
    rdv_d     = rdv_q;
    rd_pos_d  = rd_pos_q;
    wpos_d    = wpos_q;
    n_d       = n_q;
    pend_d    = pend_q;
    ins_d     = ins_q;
    ram_we    = 1'b0;
    ram_waddr = pos_slot;
    ram_wdata = val_q;

    if (cmd_i.decode) begin
      status_d = STAT_OK;
      rdv_d    = '0;
      pend_d   = 1'b0;
      n_d      = '0;
      unique case (op_q)
        OP_PUSH_BACK: begin
          if (full) begin
            status_d = STAT_FULL;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = slot_add(head_q, count_q[SlotW-1:0]);
            count_d   = count_q + CntW'(1);
          end
        end
        OP_PUSH_FRONT: begin
          if (full) begin
            status_d = STAT_FULL;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = head_dec;
            head_d    = head_dec;
            count_d   = count_q + CntW'(1);
          end
        end
        OP_POP_BACK: begin
          if (empty) begin
            status_d = STAT_EMPTY;
          end else begin
            count_d = count_q - CntW'(1);
          end
        end
        OP_POP_FRONT: begin
          if (empty) begin
            status_d = STAT_EMPTY;
          end else begin
            head_d  = head_inc;
            count_d = count_q - CntW'(1);
          end
        end
        OP_INSERT: begin
          if (!pos_ok) begin
            status_d = STAT_RANGE;
          end else if (full) begin
            status_d = STAT_FULL;
          end else if (pos_zero) begin
            ram_we    = 1'b1;
            ram_waddr = head_dec;
            head_d    = head_dec;
            count_d   = count_q + CntW'(1);
          end else begin
            // move tail..pos up one slot, starting at the tail
            ins_d    = 1'b1;
            rd_pos_d = SlotW'(count_q - CntW'(1));
            n_d      = count_q - CntW'(pos_q);
          end
        end
        OP_READ: begin
          if (!pos_ok) begin
            status_d = STAT_RANGE;
          end
        end
        OP_WRITE: begin
          if (!pos_ok) begin
            status_d = STAT_RANGE;
          end else begin
            ram_we = 1'b1;
          end
        end
        OP_REMOVE: begin
          if (!pos_ok) begin
            status_d = STAT_RANGE;
          end else if (pos_zero) begin
            head_d  = head_inc;
            count_d = count_q - CntW'(1);
          end else if (pos_last) begin
            count_d = count_q - CntW'(1);
          end else begin
            // move pos+1..tail down one slot, starting next to pos
            ins_d    = 1'b0;
            rd_pos_d = SlotW'(pos_q) + SlotW'(1);
            n_d      = count_q - CntW'(pos_q) - CntW'(1);
          end
        end
        OP_CLEAR: begin
          count_d = '0;
          head_d  = '0;
        end
        default: begin
        end
      endcase
    end

    if (cmd_i.shift) begin
      // read one entry per cycle, write it back in the following cycle
      if (n_q != '0) begin
        n_d      = n_q - CntW'(1);
        rd_pos_d = ins_q ? rd_pos_q - SlotW'(1) : rd_pos_q + SlotW'(1);
        wpos_d   = ins_q ? rd_pos_q + SlotW'(1) : rd_pos_q - SlotW'(1);
        pend_d   = 1'b1;
      end else begin
        pend_d = 1'b0;
      end
      if (pend_q) begin
        ram_we    = 1'b1;
        ram_waddr = slot_add(head_q, wpos_q);
        ram_wdata = ram_rdata;
      end else if (n_q == '0) begin
        if (ins_q) begin
          ram_we  = 1'b1;
          count_d = count_q + CntW'(1);
        end else begin
          count_d = count_q - CntW'(1);
        end
      end
    end

    if (cmd_i.capture_rd) begin
      rdv_d = ram_rdata;
    end
  end

  idl_ram #(
    .WIDTH (ValW),
    .DEPTH (Capacity)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
      pend_q  <= 1'b0;
      n_q     <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
      pend_q  <= pend_d;
      n_q     <= n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      op_q  <= req_op_i;
      pos_q <= req_pos_i;
      val_q <= req_value_i;
    end
    rd_pos_q <= rd_pos_d;
    wpos_q   <= wpos_d;
    ins_q    <= ins_d;
    status_q <= status_d;
    rdv_q    <= rdv_d;
    if (cmd_i.load_out) begin
      out_value_o  <= rdv_q;
      out_status_o <= status_q;
      out_count_o  <= OutCntW'(count_q);
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Capacity))
    else $error("entry count above capacity");

  a_head_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, head_q} < (SlotW+1)'(Capacity))
    else $error("head slot outside the store");

  a_shift_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.shift && n_q != '0) |=> pend_q)
    else $error("shift read without pending write-back");

endmodule

FILE: hdl/idl_ctrl.sv
// Controller: request sequencing state machine and output valid register.
module idl_ctrl import idl_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     s_tvalid_i,
  output logic     s_tready_o,
  output logic     m_tvalid_o,
  input  logic     m_tready_i,
  output dp_cmd_t  cmd_o,
  input  dp_stat_t stat_i
);

  fsm_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (s_tvalid_i) begin
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        priority if (stat_i.shift_needed) begin
          state_d = S_SHIFT;
        end else if (stat_i.read_needed) begin
          state_d = S_RDWAIT;
        end else begin
          state_d = S_DONE;
        end
      end
      S_SHIFT: begin
        if (stat_i.shift_done) begin
          state_d = S_DONE;
        end
      end
      S_RDWAIT: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || m_tready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    s_tready_o          = state_q == S_IDLE;
    cmd_o.load_req      = (state_q == S_IDLE) && s_tvalid_i;
    cmd_o.decode        = state_q == S_DECODE;
    cmd_o.shift         = state_q == S_SHIFT;
    cmd_o.capture_rd    = state_q == S_RDWAIT;
    // result register is free, or its transfer completes this cycle
    cmd_o.load_out      = (state_q == S_DONE) && (!out_valid_q || m_tready_i);
    out_valid_d         = out_valid_q && !m_tready_i;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end
  end

  assign m_tvalid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_done_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && out_valid_q && !m_tready_i) |=> state_q == S_DONE)
    else $error("result overwrote an untaken result");

endmodule

FILE: tb/tb_indexed_deque_list.sv
// Testbench for indexed_deque_list: random list requests checked against a behavioral list.
module tb_indexed_deque_list;
  import idl_pkg::*;

  localparam int StallLimit = 20000;
  localparam int HoldCycles = 3000;
  localparam logic [OpW-1:0] OpUnusedLo = 4'd9;
  localparam logic [OpW-1:0] OpUnusedHi = 4'd15;

  typedef enum int {MIX_PHASE, GROW_PHASE, FULL_PHASE, DRAIN_PHASE} stim_mode_e;
  typedef enum int {READY_ALWAYS, READY_RANDOM, READY_PERIODIC, READY_SPARSE} ready_mode_e;

  typedef struct packed {
    logic [ValW-1:0]    read_value;
    status_e            status;
    logic [OutCntW-1:0] count;
  } reply_t;

  // Behavioral copy of the list plus the replies still owed by the block.
  class deque_scoreboard;
    logic [ValW-1:0] slots [Capacity];
    int     head;
    int     length;
    reply_t pending_replies [$];
    int     noted;
    int     errors;

    function int slot_of(int pos);
      return (head + pos) % Capacity;
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    function void note_request(logic [OpW-1:0] op, logic [PosW-1:0] pos_f,
                               logic [ValW-1:0] val);
      reply_t r;
      int pos;
      int k;
      pos = int'(pos_f);
      r.read_value = '0;
      r.status = STAT_OK;
      case (op)
        OP_PUSH_BACK: begin
          if (length >= Capacity) r.status = STAT_FULL;
          else begin
            slots[slot_of(length)] = val;
            length++;
          end
        end
        OP_PUSH_FRONT: begin
          if (length >= Capacity) r.status = STAT_FULL;
          else begin
            head = (head + Capacity - 1) % Capacity;
            slots[head] = val;
            length++;
          end
        end
        OP_POP_BACK: begin
          if (length == 0) r.status = STAT_EMPTY;
          else length--;
        end
        OP_POP_FRONT: begin
          if (length == 0) r.status = STAT_EMPTY;
          else begin
            head = (head + 1) % Capacity;
            length--;
          end
        end
        OP_INSERT: begin
          // range test wins over the full test
          if (pos >= length) r.status = STAT_RANGE;
          else if (length >= Capacity) r.status = STAT_FULL;
          else begin
            if (pos == 0) begin
              head = (head + Capacity - 1) % Capacity;
              slots[head] = val;
            end else begin
              for (k = length; k > pos; k--) slots[slot_of(k)] = slots[slot_of(k - 1)];
              slots[slot_of(pos)] = val;
            end
            length++;
          end
        end
        OP_READ: begin
          if (pos >= length) r.status = STAT_RANGE;
          else r.read_value = slots[slot_of(pos)];
        end
        OP_WRITE: begin
          if (pos >= length) r.status = STAT_RANGE;
          else slots[slot_of(pos)] = val;
        end
        OP_REMOVE: begin
          if (pos >= length) r.status = STAT_RANGE;
          else begin
            if (pos == 0) head = (head + 1) % Capacity;
            else for (k = pos; k + 1 < length; k++) slots[slot_of(k)] = slots[slot_of(k + 1)];
            length--;
          end
        end
        OP_CLEAR: begin
          length = 0;
          head = 0;
        end
        default: ;
      endcase
      r.count = OutCntW'(length);
      pending_replies.insert(pending_replies.size(), r);
      noted++;
    endfunction

    task check_result(logic [47:0] beat);
      reply_t want;
      if (pending_replies.size() == 0) begin
        report($sformatf("result %h with no request outstanding", beat));
        return;
      end
      want = pending_replies[0];
      pending_replies.delete(0);
      if (beat[31:0] !== want.read_value)
        report($sformatf("read_value %h, expected %h", beat[31:0], want.read_value));
      if (beat[33:32] !== want.status)
        report($sformatf("status %0d, expected %0d", beat[33:32], want.status));
      if (beat[42:34] !== want.count)
        report($sformatf("count %0d, expected %0d", beat[42:34], want.count));
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;   // [7:0] position, [39:8] value
  logic [3:0]  s_tuser;   // [3:0] op
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;   // [31:0] read_value, [33:32] status, [42:34] count

  deque_scoreboard sb;
  int burst_left;
  bit gaps_on;
  int quiet_cycles = 0;

  indexed_deque_list dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && s_tvalid && s_tready) sb.note_request(s_tuser, s_tdata[7:0], s_tdata[39:8]);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) sb.check_result(m_tdata);
  end

  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side: shifting stall patterns, plus one long hold-off to back up the block
  initial begin
    ready_mode_e mode;
    int span;
    int tick;
    bit held;
    m_tready = 1'b0;
    mode = READY_ALWAYS;
    span = 0;
    tick = 0;
    held = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (!held && sb.noted >= 150) begin
        held = 1;
        m_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end
      if (span == 0) begin
        mode = ready_mode_e'($urandom_range(READY_SPARSE, READY_ALWAYS));
        span = $urandom_range(400, 40);
      end
      span--;
      tick++;
      case (mode)
        READY_ALWAYS:   m_tready <= 1'b1;
        READY_RANDOM:   m_tready <= ($urandom_range(3) != 0);
        READY_PERIODIC: m_tready <= ((tick % 5) < 3);
        default:        m_tready <= ($urandom_range(4) == 0);
      endcase
    end
  end

  // Holds valid until the transfer, then maybe ends the burst with a gap.
  task automatic send_item(logic [OpW-1:0] op, logic [PosW-1:0] pos, logic [ValW-1:0] val);
    int gap;
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {val, pos};
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(24, 1);
      gap = 0;
      if (gaps_on) gap = ($urandom_range(9) < 8) ? $urandom_range(6, 1) : $urandom_range(60, 7);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_replies.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_random(stim_mode_e mode);
    int r;
    int rp;
    int cnt;
    logic [OpW-1:0]  op;
    logic [PosW-1:0] pos;
    logic [ValW-1:0] val;
    r = $urandom_range(99);
    cnt = sb.length;
    case (mode)
      GROW_PHASE: begin
        if (r < 40) op = OP_PUSH_BACK;
        else if (r < 65) op = OP_PUSH_FRONT;
        else if (r < 85) op = OP_INSERT;
        else if (r < 92) op = OP_READ;
        else if (r < 97) op = OP_WRITE;
        else op = OP_REMOVE;
      end
      FULL_PHASE: begin
        if (r < 18) op = OP_PUSH_BACK;
        else if (r < 32) op = OP_PUSH_FRONT;
        else if (r < 50) op = OP_INSERT;
        else if (r < 58) op = OP_POP_BACK;
        else if (r < 64) op = OP_POP_FRONT;
        else if (r < 76) op = OP_REMOVE;
        else if (r < 88) op = OP_READ;
        else op = OP_WRITE;
      end
      DRAIN_PHASE: begin
        if (r < 28) op = OP_POP_BACK;
        else if (r < 52) op = OP_POP_FRONT;
        else if (r < 82) op = OP_REMOVE;
        else if (r < 90) op = OP_READ;
        else if (r < 96) op = OP_WRITE;
        else op = OP_INSERT;
      end
      default: begin
        if (r < 3) op = 4'($urandom_range(OpUnusedHi, OpUnusedLo));
        else if (r < 7) op = OP_CLEAR;
        else op = 4'($urandom_range(OP_REMOVE, OP_PUSH_BACK));
      end
    endcase
    // mostly in-range positions, with the ends favored
    rp = $urandom_range(99);
    if (cnt == 0 || rp < 12) pos = 8'($urandom_range(255));
    else if (rp < 30) pos = '0;
    else if (rp < 48) pos = 8'(cnt - 1);
    else pos = 8'($urandom_range(cnt - 1));
    case ($urandom_range(19))
      0: val = 32'h8000_0000;
      1: val = 32'h7fff_ffff;
      2: val = 32'hffff_ffff;
      3: val = '0;
      default: val = $urandom;
    endcase
    send_item(op, pos, val);
  endtask

  function automatic bit phase_goal(stim_mode_e mode);
    case (mode)
      GROW_PHASE:  return sb.length >= Capacity;
      DRAIN_PHASE: return sb.length == 0;
      default:     return 1'b1;
    endcase
  endfunction

  // items are counted once the phase has reached its goal; ceiling bounds the phase
  task automatic run_phase(stim_mode_e mode, int items, int ceiling);
    int n;
    int counted;
    n = 0;
    counted = 0;
    while (counted < items && n < ceiling) begin
      send_random(mode);
      n++;
      if (phase_goal(mode)) counted++;
    end
    wait_for_results();
  endtask

  initial begin
    sb = new;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    rst_ni = 1'b0;
    burst_left = 8;
    gaps_on = 1;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty list: pops, reads, writes, inserts and removes all refused
    send_item(OP_POP_BACK,  8'd0, 32'h0);
    send_item(OP_POP_FRONT, 8'd0, 32'h0);
    send_item(OP_READ,      8'd0, 32'h0);
    send_item(OP_INSERT,    8'd0, 32'h1111_1111);
    send_item(OP_REMOVE,    8'd0, 32'h0);
    send_item(OP_WRITE,     8'd0, 32'h2222_2222);
    send_item(OP_PUSH_BACK,  8'd0, 32'h7fff_ffff);
    send_item(OP_PUSH_BACK,  8'd0, 32'h8000_0000);
    send_item(OP_PUSH_FRONT, 8'd0, 32'hffff_ffff);   // head wraps below slot zero
    send_item(OP_PUSH_FRONT, 8'd0, 32'h0);
    send_item(OP_INSERT, 8'd0, 32'h1234_5678);       // front insert
    send_item(OP_INSERT, 8'd2, 32'hdead_beef);
    send_item(OP_INSERT, 8'd5, 32'h5a5a_5a5a);
    send_item(OP_READ,   8'd6, 32'h0);
    send_item(OP_READ,   8'd7, 32'h0);
    send_item(OP_WRITE,  8'd3, 32'ha5a5_a5a5);
    send_item(OP_READ,   8'd3, 32'h0);
    send_item(OP_REMOVE, 8'd6, 32'h0);               // tail
    send_item(OP_REMOVE, 8'd0, 32'h0);               // head
    send_item(OP_REMOVE, 8'd2, 32'h0);
    send_item(OP_READ,   8'd255, 32'h0);
    send_item(OpUnusedLo, 8'd1, 32'hcafe_f00d);
    send_item(OpUnusedHi, 8'd255, 32'hffff_ffff);
    send_item(OP_CLEAR,  8'd0, 32'h0);
    send_item(OP_POP_FRONT, 8'd0, 32'h0);
    wait_for_results();

    run_phase(MIX_PHASE, 40, 40);
    run_phase(GROW_PHASE, 20, 700);
    gaps_on = 0;
    run_phase(FULL_PHASE, 60, 60);
    gaps_on = 1;
    run_phase(DRAIN_PHASE, 15, 700);
    run_phase(MIX_PHASE, 40, 40);

    repeat (Capacity + 40) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_replies.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/idl_pkg.sv
hdl/idl_ram.sv
hdl/idl_datapath.sv
hdl/idl_ctrl.sv
hdl/indexed_deque_list.sv
tb/tb_indexed_deque_list.sv
